FILE: sv/emcal_channel_tower_map_core_macros.svh
// Assertion macros shared by the channel and tower map RTL.
`ifndef EMCAL_CHANNEL_TOWER_MAP_CORE_MACROS_SVH
`define EMCAL_CHANNEL_TOWER_MAP_CORE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ECTM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ectm same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ECTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ectm next-cycle check failed");

`endif

FILE: sv/ectm_pkg.sv
// Package with the board channel map, packet offsets and field widths.
package ectm_pkg;

    localparam int unsigned ChanW  = 15;
    localparam int unsigned EtaW   = 7;
    localparam int unsigned PhiW   = 8;

    localparam logic [2:0] LocalPhiMax  = 3'd7;
    localparam logic [4:0] PacketEtaMax = 5'd23;
    localparam logic [6:0] EtaLimit     = 7'd95;

    typedef logic [1:0] t_packet;

    typedef struct packed {
        logic [2:0] leta;
        logic [2:0] lphi;
    } t_cell;

    localparam logic [6:0] PACKET_ETA_BASE [4] = '{7'd24, 7'd0, 7'd48, 7'd72};
    localparam t_packet    ETA_BAND_PACKET [4] = '{2'd1, 2'd0, 2'd2, 2'd3};

    // Board channel at a local eta and phi cell.
    function automatic logic [5:0] board_chan(input logic [2:0] leta, input logic [2:0] lphi);
        return {~lphi[2:1], ~leta[2:1], ~lphi[0], leta[0]};
    endfunction

    // Local eta and phi cell of a board channel.
    function automatic t_cell board_cell(input logic [5:0] ch);
        t_cell c;
        c.leta = {~ch[3:2], ch[0]};
        c.lphi = {~ch[5:4], ~ch[1]};
        return c;
    endfunction

endpackage

FILE: sv/ectm_map.sv
// Combinational mapping between channel numbers and tower bins.
module ectm_map #(
    parameter int unsigned SUPERSECTORS = 32
) (
    input  logic                        i_mode,
    input  logic [ectm_pkg::ChanW-1:0]  i_channel_index,
    input  logic [ectm_pkg::EtaW-1:0]   i_eta_in,
    input  logic [ectm_pkg::PhiW-1:0]   i_phi_in,
    output logic [ectm_pkg::EtaW-1:0]   o_eta_out,
    output logic [ectm_pkg::PhiW-1:0]   o_phi_out,
    output logic [ectm_pkg::ChanW-1:0]  o_index_out
);

    logic [4:0] ss_tab [64];

    for (genvar g = 0; g < 64; g++) begin : g_ss_tab
        assign ss_tab[g] = 5'(g % SUPERSECTORS);
    end

    logic [6:0]           enc_hi;
    logic [14:0]          enc_prod;
    logic [5:0]           enc_ss_q;
    logic [1:0]           enc_r3;
    logic [3:0]           enc_k;
    logic [7:0]           enc_pk_prod;
    ectm_pkg::t_packet    enc_packet;
    logic [1:0]           enc_board;
    ectm_pkg::t_cell      enc_cell;
    logic                 enc_south;
    logic [2:0]           enc_lphi;
    logic [4:0]           enc_peta;
    logic [4:0]           enc_peta_m;

    always_comb begin
        enc_hi      = i_channel_index[14:8];
        enc_prod    = 15'(enc_hi) * 15'd171;
        enc_ss_q    = enc_prod[14:9];
        enc_r3      = 2'(enc_hi - 7'(enc_ss_q) * 7'd3);
        enc_k       = {enc_r3, i_channel_index[7:6]};
        enc_pk_prod = 8'(enc_k) * 8'd11;
        enc_packet  = enc_pk_prod[6:5];
        enc_board   = 2'(enc_k - 4'(enc_packet) * 4'd3);
        enc_cell    = ectm_pkg::board_cell(i_channel_index[5:0]);
        enc_south   = ~enc_packet[1];
        enc_lphi    = enc_south ? (ectm_pkg::LocalPhiMax - enc_cell.lphi) : enc_cell.lphi;
        enc_peta    = {enc_board, enc_cell.leta};
        enc_peta_m  = enc_south ? (ectm_pkg::PacketEtaMax - enc_peta) : enc_peta;
    end

    logic [6:0]           dec_eta;
    logic [7:0]           dec_band_prod;
    logic [1:0]           dec_band;
    ectm_pkg::t_packet    dec_packet;
    logic                 dec_south;
    logic [4:0]           dec_leta;
    logic [4:0]           dec_leta_m;
    logic [2:0]           dec_lphi;
    logic [4:0]           dec_ss;
    logic [8:0]           dec_k;

    always_comb begin
        dec_eta       = (i_eta_in > ectm_pkg::EtaLimit) ? ectm_pkg::EtaLimit : i_eta_in;
        dec_band_prod = 8'(dec_eta[6:3]) * 8'd11;
        dec_band      = dec_band_prod[6:5];
        dec_packet    = ectm_pkg::ETA_BAND_PACKET[dec_band];
        dec_south     = ~dec_packet[1];
        dec_leta      = 5'(dec_eta - ectm_pkg::PACKET_ETA_BASE[dec_packet]);
        dec_leta_m    = dec_south ? (ectm_pkg::PacketEtaMax - dec_leta) : dec_leta;
        dec_lphi      = dec_south ? (ectm_pkg::LocalPhiMax - i_phi_in[2:0]) : i_phi_in[2:0];
        dec_ss        = ss_tab[{1'b0, i_phi_in[7:3]}];
        dec_k         = 9'(dec_ss) * 9'd12 + 9'(dec_packet) * 9'd3 + 9'(dec_leta_m[4:3]);
    end

    always_comb begin
        o_eta_out   = '0;
        o_phi_out   = '0;
        o_index_out = '0;
        if (!i_mode) begin
            o_eta_out = 7'(enc_peta_m) + ectm_pkg::PACKET_ETA_BASE[enc_packet];
            o_phi_out = {ss_tab[enc_ss_q], enc_lphi};
        end else begin
            o_index_out = {dec_k, ectm_pkg::board_chan(dec_leta_m[2:0], dec_lphi)};
        end
    end

endmodule

FILE: sv/emcal_channel_tower_map_core.sv
// Top level of the calorimeter channel and tower map with its pipeline registers.
//
// The input channel carries one beat per item: mode, channel_index, eta_in and
// phi_in. Mode 0 turns a readout channel number into tower eta and phi bins,
// mode 1 turns tower bins back into a channel number; the unused outputs read
// zero. A beat is taken when i_in_valid is high and o_in_stall is low, and a
// result beat leaves when o_out_valid is high and i_out_stall is low.
// Each beat passes an input register, one level of mapping logic and a result
// register, so the result is presented from the result register and can leave
// while i_out_stall is low. One beat is taken every cycle while the receiver
// does not stall; the rate is set by the single mapping stage between the two
// registers. When the receiver stalls, the result register holds its beat, the
// input register still fills, and only then is o_in_stall raised.
// A synchronous reset empties both registers; no beat is in flight afterwards.
`include "emcal_channel_tower_map_core_macros.svh"

module emcal_channel_tower_map_core #(
    parameter int unsigned SUPERSECTORS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_mode,
    input  logic [ectm_pkg::ChanW-1:0]  i_channel_index,
    input  logic [ectm_pkg::EtaW-1:0]   i_eta_in,
    input  logic [ectm_pkg::PhiW-1:0]   i_phi_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ectm_pkg::EtaW-1:0]   o_eta_out,
    output logic [ectm_pkg::PhiW-1:0]   o_phi_out,
    output logic [ectm_pkg::ChanW-1:0]  o_index_out
);

    logic                       r_in_vld;
    logic                       r_mode;
    logic [ectm_pkg::ChanW-1:0] r_chan;
    logic [ectm_pkg::EtaW-1:0]  r_eta;
    logic [ectm_pkg::PhiW-1:0]  r_phi;

    logic                       r_out_vld;
    logic [ectm_pkg::EtaW-1:0]  r_eta_out;
    logic [ectm_pkg::PhiW-1:0]  r_phi_out;
    logic [ectm_pkg::ChanW-1:0] r_index_out;

    logic [ectm_pkg::EtaW-1:0]  n_eta_out;
    logic [ectm_pkg::PhiW-1:0]  n_phi_out;
    logic [ectm_pkg::ChanW-1:0] n_index_out;

    logic out_free;
    logic in_free;

    assign out_free = !r_out_vld || !i_out_stall;
    assign in_free  = !r_in_vld || out_free;

    ectm_map #(
        .SUPERSECTORS(SUPERSECTORS)
    ) u_map (
        .i_mode          (r_mode),
        .i_channel_index (r_chan),
        .i_eta_in        (r_eta),
        .i_phi_in        (r_phi),
        .o_eta_out       (n_eta_out),
        .o_phi_out       (n_phi_out),
        .o_index_out     (n_index_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_mode <= i_mode;
            r_chan <= i_channel_index;
            r_eta  <= i_eta_in;
            r_phi  <= i_phi_in;
        end
        if (out_free && r_in_vld) begin
            r_eta_out   <= n_eta_out;
            r_phi_out   <= n_phi_out;
            r_index_out <= n_index_out;
        end
    end

    assign o_in_stall  = !in_free;
    assign o_out_valid = r_out_vld;
    assign o_eta_out   = r_eta_out;
    assign o_phi_out   = r_phi_out;
    assign o_index_out = r_index_out;

    `ECTM_ASSERT_NEXT(a_accept_fills, i_in_valid && !o_in_stall, r_in_vld)
    `ECTM_ASSERT_NOW(a_eta_range, o_out_valid, o_eta_out <= ectm_pkg::EtaLimit)
    `ECTM_ASSERT_NOW(a_mode_exclusive, o_out_valid && (o_index_out != '0), {o_eta_out, o_phi_out} == '0)

endmodule
